@@ design/fxalu_pkg.sv @@
// Package with constants, item types and operation codes of the Q24.8 fixed-point ALU.
package fxalu_pkg;

  localparam int FRAC_BITS   = 8;
  localparam int DATA_W      = 32;
  localparam int QUOT_W      = DATA_W + FRAC_BITS;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam logic [DATA_W:0] ROUND_HALF = (DATA_W + 1)'(1) << (FRAC_BITS - 1);

  typedef enum logic [3:0] {
    FN_ADD     = 4'd0,
    FN_SUB     = 4'd1,
    FN_MUL     = 4'd2,
    FN_DIV     = 4'd3,
    FN_LT      = 4'd4,
    FN_GT      = 4'd5,
    FN_LE      = 4'd6,
    FN_GE      = 4'd7,
    FN_EQ      = 4'd8,
    FN_NE      = 4'd9,
    FN_MIN     = 4'd10,
    FN_MAX     = 4'd11,
    FN_INC     = 4'd12,
    FN_DEC     = 4'd13,
    FN_TOINT   = 4'd14,
    FN_FROMINT = 4'd15
  } func_t;

  typedef enum logic [1:0] {
    CL_SIMPLE = 2'd0,
    CL_MUL    = 2'd1,
    CL_DIV    = 2'd2,
    CL_TOINT  = 2'd3
  } cls_t;

  typedef struct packed {
    func_t              func;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               compare_true;
    logic               divide_by_zero;
  } rsp_t;

  typedef struct packed {
    func_t                    func;
    cls_t                     cls;
    logic                     lt;
    logic                     eq;
    logic                     b_zero;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } op_t;

  typedef struct packed {
    cls_t              cls;
    logic              qneg;
    logic [DATA_W-1:0] r;
    logic              cmp;
    logic              dz;
  } line_t;

endpackage

@@ design/fxalu_front.sv @@
// Front stage that accepts items, classifies them and pushes them into the queue.
module fxalu_front
  import fxalu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  input  logic q_full,
  output logic push,
  output op_t  push_op
);

  logic f_v;
  op_t  f_op;
  op_t  op_next;
  logic accept;

  assign req_stall = f_v && q_full;
  assign accept    = req_valid && !req_stall;
  assign push      = f_v && !q_full;
  assign push_op   = f_op;

  always_comb begin
    op_next.func   = req.func;
    op_next.a      = req.operand_a;
    op_next.b      = req.operand_b;
    op_next.lt     = req.operand_a < req.operand_b;
    op_next.eq     = req.operand_a == req.operand_b;
    op_next.b_zero = req.operand_b == '0;
    unique case (req.func)
      FN_MUL:   op_next.cls = CL_MUL;
      FN_DIV:   op_next.cls = CL_DIV;
      FN_TOINT: op_next.cls = CL_TOINT;
      default:  op_next.cls = CL_SIMPLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (accept) begin
      f_v <= 1'b1;
    end else if (push) begin
      f_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_op <= op_next;
    end
  end

endmodule

@@ design/fxalu_queue.sv @@
// Short queue of classified items between the front and the execution pipeline.
module fxalu_queue
  import fxalu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output op_t  head
);

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = count == QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("Queue count exceeds its depth.");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("Queue popped while empty.");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full && !pop |=> count == QCNT_W'(QUEUE_DEPTH))
    else $error("Queue lost its fill level while full.");
`endif

endmodule

@@ design/fxalu_div.sv @@
// Pipelined restoring divider that produces one quotient bit per stage.
module fxalu_div
  import fxalu_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [QUOT_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic [DATA_W-1:0] quotient
);

  logic [QUOT_W-1:0] w   [QUOT_W];
  logic [DATA_W-1:0] rem [QUOT_W];
  logic [DATA_W-1:0] dv  [QUOT_W];

  for (genvar i = 0; i < QUOT_W; i++) begin : g_stage
    logic [QUOT_W-1:0] w_in;
    logic [DATA_W-1:0] rem_in;
    logic [DATA_W-1:0] dv_in;
    logic [DATA_W-1:0] rem_sh;
    logic              ge;

    if (i == 0) begin : g_first
      assign w_in   = dividend;
      assign rem_in = '0;
      assign dv_in  = divisor;
    end else begin : g_next
      assign w_in   = w[i-1];
      assign rem_in = rem[i-1];
      assign dv_in  = dv[i-1];
    end

    assign rem_sh = {rem_in[DATA_W-2:0], w_in[QUOT_W-1]};
    assign ge     = rem_sh >= dv_in;

    always_ff @(posedge clk) begin
      if (en) begin
        w[i]   <= {w_in[QUOT_W-2:0], ge};
        rem[i] <= ge ? rem_sh - dv_in : rem_sh;
        dv[i]  <= dv_in;
      end
    end
  end

  assign quotient = w[QUOT_W-1][DATA_W-1:0];

endmodule

@@ design/fxalu_back.sv @@
// Execution pipeline: operand stage, divider-length result line and output register.
module fxalu_back
  import fxalu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_not_empty,
  input  op_t  head,
  output logic pop,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic en;

  logic                     s0_v;
  cls_t                     s0_cls;
  logic [DATA_W-1:0]        s0_r;
  logic                     s0_cmp;
  logic                     s0_dz;
  logic signed [PROD_W-1:0] s0_prod;
  logic [DATA_W-1:0]        s0_amag;
  logic [DATA_W-1:0]        s0_bmag;
  logic                     s0_asign;
  logic                     s0_qneg;

  logic [DATA_W-1:0]        r0;
  logic                     cmp0;
  logic                     gt0;

  logic [DATA_W:0]          rnd_sum;
  logic [DATA_W-1:0]        rnd_mag;
  line_t                    line_in;
  line_t                    line [QUOT_W];
  logic [QUOT_W-1:0]        line_v;

  logic [DATA_W-1:0]        quotient;
  line_t                    last;
  rsp_t                     rsp_next;

  assign en  = !(rsp_valid && rsp_stall);
  assign pop = en && q_not_empty;
  assign gt0 = !head.lt && !head.eq;

  always_comb begin
    r0   = '0;
    cmp0 = 1'b0;
    unique case (head.func)
      FN_ADD:     r0 = head.a + head.b;
      FN_SUB:     r0 = head.a - head.b;
      FN_MUL:     r0 = '0;
      FN_DIV:     r0 = '0;
      FN_LT:      cmp0 = head.lt;
      FN_GT:      cmp0 = gt0;
      FN_LE:      cmp0 = head.lt || head.eq;
      FN_GE:      cmp0 = !head.lt;
      FN_EQ:      cmp0 = head.eq;
      FN_NE:      cmp0 = !head.eq;
      FN_MIN:     r0 = head.lt ? head.a : head.b;
      FN_MAX:     r0 = gt0 ? head.a : head.b;
      FN_INC:     r0 = head.a + 1'b1;
      FN_DEC:     r0 = head.a - 1'b1;
      FN_TOINT:   r0 = '0;
      FN_FROMINT: r0 = DATA_W'(head.a <<< FRAC_BITS);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_cls   <= head.cls;
      s0_r     <= r0;
      s0_cmp   <= cmp0;
      s0_dz    <= (head.cls == CL_DIV) && head.b_zero;
      s0_prod  <= PROD_W'(head.a) * PROD_W'(head.b);
      s0_amag  <= head.a[DATA_W-1] ? ~head.a + 1'b1 : head.a;
      s0_bmag  <= head.b[DATA_W-1] ? ~head.b + 1'b1 : head.b;
      s0_asign <= head.a[DATA_W-1];
      s0_qneg  <= head.a[DATA_W-1] ^ head.b[DATA_W-1];
    end
  end

  assign rnd_sum = {1'b0, s0_amag} + ROUND_HALF;
  assign rnd_mag = DATA_W'(rnd_sum >> FRAC_BITS);

  always_comb begin
    line_in.cls  = s0_cls;
    line_in.qneg = s0_qneg;
    line_in.cmp  = s0_cmp;
    line_in.dz   = s0_dz;
    unique case (s0_cls)
      CL_MUL:    line_in.r = s0_prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
      CL_TOINT:  line_in.r = s0_asign ? ~rnd_mag + 1'b1 : rnd_mag;
      CL_DIV:    line_in.r = '0;
      CL_SIMPLE: line_in.r = s0_r;
    endcase
  end

  fxalu_div u_div (
    .clk      (clk),
    .en       (en),
    .dividend ({s0_amag, {FRAC_BITS{1'b0}}}),
    .divisor  (s0_bmag),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line_v <= '0;
    end else if (en) begin
      line_v <= {line_v[QUOT_W-2:0], s0_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= line_in;
      for (int k = 1; k < QUOT_W; k++) begin
        line[k] <= line[k-1];
      end
    end
  end

  assign last = line[QUOT_W-1];

  always_comb begin
    rsp_next.compare_true   = last.cmp;
    rsp_next.divide_by_zero = last.dz;
    if (last.cls == CL_DIV && !last.dz) begin
      rsp_next.result = last.qneg ? ~quotient + 1'b1 : quotient;
    end else begin
      rsp_next.result = last.r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= line_v[QUOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_dz_zero_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.divide_by_zero |-> rsp.result == '0 && !rsp.compare_true)
    else $error("Divide by zero item carries a nonzero result or compare flag.");
  a_pop_fills_s0: assert property (@(posedge clk) disable iff (rst)
    pop |=> s0_v)
    else $error("Popped item did not reach the operand stage.");
  a_line_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(line_v) && $stable(s0_v))
    else $error("Pipeline moved while the output was stalled.");
`endif

endmodule

@@ design/fixed_point_alu_q24_8_top.sv @@
// Top level of the signed Q24.8 fixed-point ALU.
//
// The request channel (req_valid, req_stall, req) takes one item per cycle
// while req_stall is low: an operation code and two raw 32-bit operands. The
// response channel (rsp_valid, rsp_stall, rsp) returns exactly one result item per request, in order.
// An item is taken at a clock edge where valid is high and stall is low.
// An accepted item passes the front register, the queue, the operand stage,
// the divider-length result line and the output register.
// The result line is as long as the pipelined divider, which resolves one
// quotient bit per stage; every operation follows the same path so order
// is kept. Throughput is one item per cycle while nothing stalls.
// A four-entry queue separates the input stage from the execution pipeline.
// When the receiver stalls, the execution pipeline holds, the response stays
// unchanged, and the queue keeps taking items until it fills; then req_stall
// rises. A synchronous reset on rst empties the block at once.
module fixed_point_alu_q24_8_top
  import fxalu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic q_full;
  logic push;
  op_t  push_op;
  logic pop;
  logic q_not_empty;
  op_t  head;

  fxalu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op)
  );

  fxalu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (head)
  );

  fxalu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (pop),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp)
  );

endmodule
